>>> src/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Types and constants shared by the epoch-seconds to calendar converter.
// ----------------------------------------------------------------------------
package esc_pkg;

	// Input item: seconds since 1970-01-01 00:00:00
	typedef struct packed {
		logic [31:0] epoch_seconds;
	} secs_item_t;

	// Result item: calendar date and time of day
	typedef struct packed {
		logic [11:0] cal_year;
		logic [3:0]  cal_month;
		logic [4:0]  cal_day;
		logic [4:0]  clock_hour;
		logic [5:0]  clock_minute;
		logic [5:0]  clock_second;
	} cal_item_t;

	// Stage load enables handed to the date and time paths
	typedef struct packed {
		logic s3;
		logic s4;
	} esc_adv_t;

	localparam logic [11:0] BASE_YEAR = 12'd1970;

	// floor(t / 86400) = floor((t >> 7) * DAY_RECIP >> 35), exact for 32-bit t
	localparam logic [25:0] DAY_RECIP = 26'd50903317;

	// floor(4d / 1461) for d < 2^16: year estimate, off by at most one
	localparam logic [18:0] YEAR_RECIP = 19'd367469;

	// floor(r / 3600) = floor((r >> 4) * HOUR_RECIP >> 21), r < 86400
	localparam logic [13:0] HOUR_RECIP = 14'd9321;

	// floor(r / 60) = floor((r >> 2) * MIN_RECIP >> 19), r < 86400
	localparam logic [15:0] MIN_RECIP = 16'd34953;

	// Year offset of 2100, the one century year in range that is not leap
	localparam logic [7:0] SKIP_LEAP_OFS = 8'd130;

	// First day of each month in a common year, counted from January 1
	localparam logic [8:0] MONTH_START [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// Day number (from 1970-01-01) of January 1 of year 1970 + ofs
	function automatic logic [15:0] year_start(input logic [7:0] ofs);
		logic [8:0]  ofs_p1;
		logic [15:0] leaps;
		ofs_p1 = {1'b0, ofs} + 9'd1;
		// leap years in [1970, 1970 + ofs), skipping 2100
		leaps = 16'(ofs_p1[8:2]) - ((ofs > SKIP_LEAP_OFS) ? 16'd1 : 16'd0);
		return 16'(16'(ofs) * 16'd365) + leaps;
	endfunction

endpackage

>>> src/esc_stream_if.sv
// ----------------------------------------------------------------------------
// esc_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface esc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Unsigned 32-bit seconds since 1970-01-01 00:00:00 to Gregorian date and time.
// ----------------------------------------------------------------------------
// Usage:
//   secs (sink) takes one epoch_seconds value per transfer; cal (source)
//   returns one result per input: year, month, day, hour, minute, second.
//   Every 32-bit input is valid and maps to 1970-01-01 .. 2106-02-07.
// Stages: the transfer loads the input register, then the day split, year
//   estimate, year correction and result register follow in that order.
// Throughput: one item per cycle while cal.ready is high; the rate is set by
//   the five pipeline registers, each of which can load in every cycle.
// Stalls: while cal.ready is low, each stage holds only if the one after it
//   is full, so bubbles close up and inputs keep flowing until every stage,
//   the result register included, holds an item.
// Reset: arst_n clears all stage valid flags; no result is presented and
//   the block is ready at once.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar
	import esc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	esc_stream_if.sink   secs,
	esc_stream_if.source cal
);

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic        ld_s1, ld_s2, ld_s3, ld_s4, ld_s5;
	logic [31:0] t_s1;
	logic [15:0] days_s2;
	logic [16:0] tlo_s2;
	cal_item_t   res_s5;

	logic [50:0] day_prod;
	esc_adv_t    adv;
	logic [11:0] cal_year;
	logic [3:0]  cal_month;
	logic [4:0]  cal_day;
	logic [4:0]  clock_hour;
	logic [5:0]  clock_minute;
	logic [5:0]  clock_second;

	// A stage loads when it is empty or the stage after it moves on
	assign ld_s5 = !vld_s5 || cal.ready;
	assign ld_s4 = !vld_s4 || ld_s5;
	assign ld_s3 = !vld_s3 || ld_s4;
	assign ld_s2 = !vld_s2 || ld_s3;
	assign ld_s1 = !vld_s1 || ld_s2;

	assign secs.ready = ld_s1;
	assign adv.s3     = ld_s3;
	assign adv.s4     = ld_s4;

	// Advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (ld_s1) vld_s1 <= secs.valid;
			if (ld_s2) vld_s2 <= vld_s1;
			if (ld_s3) vld_s3 <= vld_s2;
			if (ld_s4) vld_s4 <= vld_s3;
			if (ld_s5) vld_s5 <= vld_s4;
		end
	end

	// Capture the input
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			t_s1 <= secs.data.epoch_seconds;
		end
	end

	// Split off whole days: floor((t >> 7) / 675)
	assign day_prod = 51'(t_s1[31:7]) * 51'(DAY_RECIP);

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			days_s2 <= day_prod[50:35];
			tlo_s2  <= t_s1[16:0];
		end
	end

	esc_date_path u_date (
		.clk       (clk),
		.adv       (adv),
		.days      (days_s2),
		.cal_year  (cal_year),
		.cal_month (cal_month),
		.cal_day   (cal_day)
	);

	esc_time_path u_time (
		.clk          (clk),
		.adv          (adv),
		.days         (days_s2),
		.secs_lo      (tlo_s2),
		.clock_hour   (clock_hour),
		.clock_minute (clock_minute),
		.clock_second (clock_second)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (ld_s5) begin
			res_s5.cal_year     <= cal_year;
			res_s5.cal_month    <= cal_month;
			res_s5.cal_day      <= cal_day;
			res_s5.clock_hour   <= clock_hour;
			res_s5.clock_minute <= clock_minute;
			res_s5.clock_second <= clock_second;
		end
	end

	assign cal.valid = vld_s5;
	assign cal.data  = res_s5;

`ifndef SYNTH
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(secs.valid && secs.ready) |=> vld_s1)
		else $error("accepted item did not reach the input register");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal.valid |-> (cal.data.cal_month >= 4'd1 && cal.data.cal_month <= 4'd12
			&& cal.data.cal_day >= 5'd1
			&& (cal.data.cal_month != 4'd2 || cal.data.cal_day <= 5'd29)))
		else $error("month or day of month out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal.valid |-> (cal.data.clock_hour < 5'd24 && cal.data.clock_minute < 6'd60
			&& cal.data.clock_second < 6'd60))
		else $error("time of day out of range");
`endif

endmodule

>>> src/esc_date_path.sv
// ----------------------------------------------------------------------------
// esc_date_path
// Day count to year, month and day of month over two pipeline stages.
// ----------------------------------------------------------------------------
module esc_date_path
	import esc_pkg::*;
(
	input  logic        clk,
	input  esc_adv_t    adv,
	input  logic [15:0] days,
	output logic [11:0] cal_year,
	output logic [3:0]  cal_month,
	output logic [4:0]  cal_day
);

	logic [15:0] days_s3;
	logic [7:0]  yest_s3;
	logic [7:0]  yoff_s4;
	logic [8:0]  doy_s4;

	logic [36:0] year_prod;
	logic [7:0]  yest_p1;
	logic [15:0] ys_cur;
	logic [15:0] ys_next;
	logic [15:0] doy_full;
	logic [7:0]  yoff;
	logic        leap;
	logic [8:0]  mstart;
	logic [8:0]  mstart_k;
	logic [3:0]  mon;

	// Estimate the year offset as floor(4 * days / 1461)
	assign year_prod = 37'({days, 2'b00}) * 37'(YEAR_RECIP);

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			days_s3 <= days;
			yest_s3 <= year_prod[36:29];
		end
	end

	// Correct the estimate by one year and find the day of year
	assign yest_p1 = yest_s3 + 8'd1;
	assign ys_cur  = year_start(yest_s3);
	assign ys_next = year_start(yest_p1);

	always_comb begin
		if (days_s3 >= ys_next) begin
			yoff     = yest_p1;
			doy_full = days_s3 - ys_next;
		end else begin
			yoff     = yest_s3;
			doy_full = days_s3 - ys_cur;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			yoff_s4 <= yoff;
			doy_s4  <= doy_full[8:0];
		end
	end

	// Pick the month whose start is the last one at or below the day of year
	assign leap = (yoff_s4[1:0] == 2'd2) && (yoff_s4 != SKIP_LEAP_OFS);

	always_comb begin
		mon    = 4'd1;
		mstart = 9'd0;
		for (int k = 0; k < 12; k++) begin
			mstart_k = MONTH_START[k] + ((leap && k >= 2) ? 9'd1 : 9'd0);
			if (doy_s4 >= mstart_k) begin
				mon    = 4'(k + 1);
				mstart = mstart_k;
			end
		end
	end

	assign cal_year  = BASE_YEAR + 12'(yoff_s4);
	assign cal_month = mon;
	assign cal_day   = 5'(doy_s4 - mstart) + 5'd1;

endmodule

>>> src/esc_time_path.sv
// ----------------------------------------------------------------------------
// esc_time_path
// Seconds within the day to hour, minute and second over two stages.
// ----------------------------------------------------------------------------
module esc_time_path
	import esc_pkg::*;
(
	input  logic        clk,
	input  esc_adv_t    adv,
	input  logic [15:0] days,
	input  logic [16:0] secs_lo,
	output logic [4:0]  clock_hour,
	output logic [5:0]  clock_minute,
	output logic [5:0]  clock_second
);

	logic [16:0] rem_s3;
	logic [16:0] rem_s4;
	logic [4:0]  hour_s4;
	logic [10:0] mt_s4;

	logic [25:0] day675;
	logic [16:0] rem;
	logic [26:0] hour_prod;
	logic [30:0] min_prod;
	logic [10:0] hour60;
	logic [10:0] min_full;
	logic [16:0] mt60;
	logic [16:0] sec_full;

	// Remainder within the day: t - days * 86400, kept modulo 2^17
	assign day675 = 26'(days) * 26'd675;
	assign rem    = secs_lo - {day675[9:0], 7'b0};

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			rem_s3 <= rem;
		end
	end

	// Whole hours and whole minutes of the day
	assign hour_prod = 27'(rem_s3[16:4]) * 27'(HOUR_RECIP);
	assign min_prod  = 31'(rem_s3[16:2]) * 31'(MIN_RECIP);

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			rem_s4  <= rem_s3;
			hour_s4 <= hour_prod[25:21];
			mt_s4   <= min_prod[29:19];
		end
	end

	// Strip the hours from the minutes and the minutes from the seconds
	assign hour60   = 11'(hour_s4) * 11'd60;
	assign min_full = mt_s4 - hour60;
	assign mt60     = 17'(mt_s4) * 17'd60;
	assign sec_full = rem_s4 - mt60;

	assign clock_hour   = hour_s4;
	assign clock_minute = min_full[5:0];
	assign clock_second = sec_full[5:0];

endmodule

>>> dv/epoch_seconds_to_calendar_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_tb
// Feeds epoch second counts through the converter and checks each date and
// time against a typed table entry or a behavioral calendar computed in the bench. A directed table
// covers range ends, day, year and leap boundaries and 2100. Random stamps
// and random idling on both channels follow.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_tb;
	import esc_pkg::*;

	localparam int unsigned SECS_PER_DAY  = 86400;
	localparam int unsigned SECS_PER_HOUR = 3600;
	localparam int unsigned SECS_PER_MIN  = 60;
	localparam int unsigned FIRST_YEAR    = 1970;
	localparam int unsigned LAST_DAY      = 49710;  // day number of 2106-02-07
	localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	// Leap Februaries, 2100 and the last year, where random stamps cluster
	localparam logic [31:0] HOT_SPOTS [4] = '{
		32'd68169600, 32'd951782400, 32'd4106937599, 32'd4291747200
	};

	localparam int N_DIR        = 20;
	localparam int N_RAND       = 1630;
	localparam int N_QUIET      = 150;
	localparam int HOLD_AT      = 300;
	localparam int DRAIN_AT     = 800;
	localparam int HOLD_CYCLES  = 64;
	localparam int TAIL_CYCLES  = 12;
	localparam int STALL_LIMIT  = 2000;

	typedef struct {
		logic [31:0] secs;
		bit          typed;
		cal_item_t   cal;
	} stamp_row_t;

	logic clk;
	logic arst_n;

	esc_stream_if #(.payload_t(secs_item_t)) secs_if ();
	esc_stream_if #(.payload_t(cal_item_t))  cal_if ();

	epoch_seconds_to_calendar u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.secs   (secs_if),
		.cal    (cal_if)
	);

	cal_item_t  cal_expected [$];
	stamp_row_t stamp_rows [N_DIR];
	int         mismatches;
	int         idle_cycles;
	bit         hold_req;
	bit         quiet;

	function automatic bit is_leap(input int unsigned yr);
		return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
	endfunction

	// Split off days, then walk whole years and months
	function automatic cal_item_t calendar_of(input logic [31:0] t);
		cal_item_t   c;
		int unsigned days;
		int unsigned rem;
		int unsigned yr;
		int unsigned mon;
		int unsigned mlen;
		days = t / SECS_PER_DAY;
		rem  = t % SECS_PER_DAY;
		c.clock_hour   = 5'(rem / SECS_PER_HOUR);
		rem            = rem % SECS_PER_HOUR;
		c.clock_minute = 6'(rem / SECS_PER_MIN);
		c.clock_second = 6'(rem % SECS_PER_MIN);
		yr = FIRST_YEAR;
		while (days >= (is_leap(yr) ? 366 : 365)) begin
			days -= is_leap(yr) ? 366 : 365;
			yr++;
		end
		mon = 1;
		while (mon < 12) begin
			mlen = MONTH_DAYS[mon - 1] + ((mon == 2 && is_leap(yr)) ? 1 : 0);
			if (days < mlen) break;
			days -= mlen;
			mon++;
		end
		c.cal_year  = 12'(yr);
		c.cal_month = 4'(mon);
		c.cal_day   = 5'(days + 1);
		return c;
	endfunction

	// Offer one stamp and hold it until the transfer, then log what it must give
	task automatic push_secs(input logic [31:0] t, input cal_item_t want);
		secs_if.valid <= 1'b1;
		secs_if.data  <= secs_item_t'(t);
		do @(posedge clk); while (!secs_if.ready);
		cal_expected.push_back(want);
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Reset and known input levels from time zero
	initial begin
		arst_n        = 1'b0;
		secs_if.valid = 1'b0;
		secs_if.data  = '0;
		cal_if.ready  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Sender: directed table, then random stamps
	initial begin : stimulus
		longint      t64;
		logic [31:0] t;
		cal_item_t   want;
		mismatches = 0;
		hold_req   = 1'b0;
		quiet      = 1'b0;
		stamp_rows = '{
			'{32'd0,          1'b1, cal_item_t'{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
			'{32'hFFFFFFFF,   1'b1, cal_item_t'{12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15}},
			'{32'd86399,      1'b1, cal_item_t'{12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59}},
			'{32'd86400,      1'b1, cal_item_t'{12'd1970, 4'd1, 5'd2, 5'd0, 6'd0, 6'd0}},
			'{32'd1,          1'b0, '0},
			'{32'd59,         1'b0, '0},
			'{32'd3600,       1'b0, '0},
			'{32'd31535999,   1'b0, '0},  // end of 1970
			'{32'd31536000,   1'b0, '0},
			'{32'd68169600,   1'b0, '0},  // leap day 1972
			'{32'd94694399,   1'b0, '0},  // last second of a leap year
			'{32'd951782400,  1'b0, '0},  // leap day 2000, a 400th year
			'{32'd4106937599, 1'b0, '0},  // last second of 2100-02-21
			'{32'd4106937600, 1'b0, '0},  // 2100-02-22, in a February with no leap day
			'{32'd4291747200, 1'b0, '0},  // start of 2106
			'{32'h7FFFFFFF,   1'b0, '0},
			'{32'h80000000,   1'b0, '0},
			'{32'hAAAAAAAA,   1'b0, '0},
			'{32'h55555555,   1'b0, '0},
			'{32'hFFFFFFFE,   1'b0, '0}
		};
		wait (arst_n === 1'b1);
		@(posedge clk);
		for (int n = 0; n < N_DIR + N_RAND; n++) begin
			quiet = (n >= N_DIR + N_RAND - N_QUIET);
			if (n == HOLD_AT)
				hold_req = 1'b1;
			if (n < N_DIR) begin
				t    = stamp_rows[n].secs;
				want = stamp_rows[n].typed ? stamp_rows[n].cal : calendar_of(t);
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: t64 = longint'($urandom);
					4, 5, 6, 7: begin
						// first or last second of a random day
						t64 = longint'($urandom_range(0, LAST_DAY)) * SECS_PER_DAY;
						t64 += ($urandom_range(0, 1) != 0) ? SECS_PER_DAY - 1 : 0;
					end
					default: begin
						t64 = longint'(HOT_SPOTS[$urandom_range(0, 3)])
							+ longint'($urandom_range(0, 4 * SECS_PER_DAY))
							- longint'(2 * SECS_PER_DAY);
					end
				endcase
				if (t64 > longint'(32'hFFFFFFFF))
					t64 = longint'(32'hFFFFFFFF);
				if (t64 < 0)
					t64 = 0;
				t    = 32'(t64);
				want = calendar_of(t);
			end
			push_secs(t, want);
			// Drain once mid-run, otherwise idle in random bursts outside the quiet tail
			if (n == DRAIN_AT) begin
				secs_if.valid <= 1'b0;
				while (cal_expected.size() != 0) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				secs_if.valid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
		end
		secs_if.valid <= 1'b0;

		// Wait out the pipeline, then keep watching for strays
		while (cal_expected.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && cal_expected.size() == 0) begin
			$display("epoch_seconds_to_calendar verification clean");
		end else begin
			$display("epoch_seconds_to_calendar verification failed");
		end
		$finish;
	end

	// Receiver: random stall bursts, one long hold-off, none near the end
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				cal_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				cal_if.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				cal_if.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
		end
	end

	// Compare each result transfer with the oldest expectation; watch for hangs
	initial begin : monitor
		cal_item_t got;
		cal_item_t want;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ((secs_if.valid && secs_if.ready) || (cal_if.valid && cal_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (cal_if.valid && cal_if.ready) begin
				got = cal_if.data;
				if (cal_expected.size() == 0) begin
					$error("cal transfer with nothing expected: %0d-%0d-%0d %0d:%0d:%0d",
						got.cal_year, got.cal_month, got.cal_day,
						got.clock_hour, got.clock_minute, got.clock_second);
					mismatches++;
				end else begin
					want = cal_expected.pop_front();
					if (got.cal_year !== want.cal_year) begin
						$error("cal_year: expected %0d, got %0d", want.cal_year, got.cal_year);
						mismatches++;
					end
					if (got.cal_month !== want.cal_month) begin
						$error("cal_month: expected %0d, got %0d", want.cal_month, got.cal_month);
						mismatches++;
					end
					if (got.cal_day !== want.cal_day) begin
						$error("cal_day: expected %0d, got %0d", want.cal_day, got.cal_day);
						mismatches++;
					end
					if (got.clock_hour !== want.clock_hour) begin
						$error("clock_hour: expected %0d, got %0d",
							want.clock_hour, got.clock_hour);
						mismatches++;
					end
					if (got.clock_minute !== want.clock_minute) begin
						$error("clock_minute: expected %0d, got %0d",
							want.clock_minute, got.clock_minute);
						mismatches++;
					end
					if (got.clock_second !== want.clock_second) begin
						$error("clock_second: expected %0d, got %0d",
							want.clock_second, got.clock_second);
						mismatches++;
					end
				end
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$error("no transfer for %0d cycles, %0d results outstanding",
					idle_cycles, cal_expected.size());
				$display("epoch_seconds_to_calendar verification failed");
				$finish;
			end
		end
	end

endmodule
